// ===== rtl/mmpp_pkg.sv =====
// shared types, constants and helpers of the motion model point projector
// depends on nothing; every other file refers to it by scoped names
`timescale 1ns / 1ps

package mmpp_pkg;

  // widths of the datapath
  localparam int CW   = 33;        // coefficient after select, room for negation
  localparam int NW   = 49;        // signed numerator and divisor
  localparam int MW   = 48;        // magnitude of numerator and divisor
  localparam int OW   = 48;        // output words
  localparam int QW   = 50;        // raw quotient bits, one below the rounding point
  localparam int FRAC = 30;        // fraction bits of the divisor
  localparam int LOW  = QW - FRAC - 1; // numerator bits fed into the divider

  localparam logic signed [NW-1:0] PERSP_ONE = NW'(64'sd1 <<< FRAC);
  localparam logic [MW-1:0] BAD_DIV_LIMIT = MW'(1073);
  localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};
  localparam logic [OW-1:0] RES_MAX = {OW{1'b1}};

  // motion model codes, unlisted codes run as homography
  typedef enum logic [2:0] {
    OP_TRANS   = 3'd0,
    OP_ROTZOOM = 3'd1,
    OP_AFFINE  = 3'd2,
    OP_HTRAP   = 3'd3,
    OP_VTRAP   = 3'd4,
    OP_HOMOG   = 3'd5
  } op_e;

  // register indexes
  typedef enum logic [2:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_COEF_XX  = 3'd2,
    REG_COEF_XY  = 3'd3,
    REG_COEF_YX  = 3'd4,
    REG_COEF_YY  = 3'd5,
    REG_PERSP_X  = 3'd6,
    REG_PERSP_Y  = 3'd7
  } reg_e;

  typedef struct packed {
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [31:0] coef_xx;
    logic [31:0] coef_xy;
    logic [31:0] coef_yx;
    logic [31:0] coef_yy;
    logic [31:0] persp_x;
    logic [31:0] persp_y;
  } cfg_t;

  // per item data that rides alongside the divider
  typedef struct packed {
    logic          persp;
    logic          bad;
    logic          last;
    logic          ovf_x;
    logic          ovf_y;
    logic          neg_x;
    logic          neg_y;
    logic [15:0]   dst_x;
    logic [15:0]   dst_y;
    logic [OW-1:0] lin_x;
    logic [OW-1:0] lin_y;
  } side_t;

  // one restoring division lane
  typedef struct packed {
    logic [MW-1:0]  r;
    logic [LOW-1:0] lo;
    logic [QW-1:0]  q;
  } lane_t;

  typedef struct packed {
    lane_t         lx;
    lane_t         ly;
    logic [MW-1:0] den;
    side_t         side;
  } div_t;

  typedef struct packed {
    logic [OW-1:0] proj_x;
    logic [OW-1:0] proj_y;
    logic [OW-1:0] resid;
    logic          inlier;
    logic          bad;
    logic          last;
  } res_t;

  // clamp a signed numerator to the output range
  function automatic logic [OW-1:0] sat_out(input logic signed [NW-1:0] v);
    logic [OW-1:0] s;
    if (v[NW-1] != v[NW-2]) begin
      s = v[NW-1] ? OUT_MIN : OUT_MAX;
    end else begin
      s = v[OW-1:0];
    end
    return s;
  endfunction

endpackage

// ===== rtl/mmpp_front.sv =====
// front end: coefficient select, products, sums, divider setup
// depends on mmpp_pkg
`timescale 1ns / 1ps

module mmpp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  logic [2:0]         opcode_i,
  input  logic signed [15:0] src_x_i,
  input  logic signed [15:0] src_y_i,
  input  logic [15:0]        dst_x_i,
  input  logic [15:0]        dst_y_i,
  input  logic               last_in_i,
  input  mmpp_pkg::cfg_t     cfg_i,
  output logic               div_valid_o,
  output mmpp_pkg::div_t     div_o
);

  localparam int CW = mmpp_pkg::CW;
  localparam int NW = mmpp_pkg::NW;
  localparam int MW = mmpp_pkg::MW;
  localparam int LOW = mmpp_pkg::LOW;

  logic signed [CW-1:0] xx, xy, yx, yy, px, py, one;
  logic signed [CW-1:0] a1, a2, b1, b2, c1, c2;
  logic                 persp;

  assign xx  = CW'($signed(cfg_i.coef_xx));
  assign xy  = CW'($signed(cfg_i.coef_xy));
  assign yx  = CW'($signed(cfg_i.coef_yx));
  assign yy  = CW'($signed(cfg_i.coef_yy));
  assign px  = CW'($signed(cfg_i.persp_x));
  assign py  = CW'($signed(cfg_i.persp_y));
  assign one = CW'(65536);

  // weights of x and y for each model
  always_comb begin
    a1 = xx; a2 = xy; b1 = yx; b2 = yy; c1 = px; c2 = py; persp = 1'b1;
    case (opcode_i)
      mmpp_pkg::OP_TRANS: begin
        a1 = one; a2 = '0; b1 = '0; b2 = one; c1 = '0; c2 = '0; persp = 1'b0;
      end
      mmpp_pkg::OP_ROTZOOM: begin
        b1 = -xy; b2 = xx; c1 = '0; c2 = '0; persp = 1'b0;
      end
      mmpp_pkg::OP_AFFINE: begin
        c1 = '0; c2 = '0; persp = 1'b0;
      end
      mmpp_pkg::OP_HTRAP: begin
        b1 = '0; c1 = '0;
      end
      mmpp_pkg::OP_VTRAP: begin
        a2 = '0; c2 = '0;
      end
      default: begin
        persp = 1'b1;
      end
    endcase
  end

  // stage 1: products
  logic signed [NW-1:0] pax_d, pay_d, pbx_d, pby_d, pcx_d, pcy_d;
  logic signed [NW-1:0] pax_q, pay_q, pbx_q, pby_q, pcx_q, pcy_q;
  logic        s1_valid_q, s1_persp_q, s1_last_q;
  logic [15:0] s1_dx_q, s1_dy_q;

  always_comb begin
    pax_d = a1 * src_x_i;
    pay_d = a2 * src_y_i;
    pbx_d = b1 * src_x_i;
    pby_d = b2 * src_y_i;
    pcx_d = c1 * src_x_i;
    pcy_d = c2 * src_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pax_q <= pax_d; pay_q <= pay_d; pbx_q <= pbx_d;
      pby_q <= pby_d; pcx_q <= pcx_d; pcy_q <= pcy_d;
      s1_persp_q <= persp;
      s1_last_q  <= last_in_i;
      s1_dx_q    <= dst_x_i;
      s1_dy_q    <= dst_y_i;
    end
  end

  // stage 2: numerators and divisor
  logic signed [NW-1:0] nx_d, ny_d, d_d, nx_q, ny_q, d_q;
  logic        s2_valid_q, s2_persp_q, s2_last_q;
  logic [15:0] s2_dx_q, s2_dy_q;

  always_comb begin
    nx_d = pax_q + pay_q + NW'($signed(cfg_i.offset_x));
    ny_d = pbx_q + pby_q + NW'($signed(cfg_i.offset_y));
    d_d  = pcx_q + pcy_q + mmpp_pkg::PERSP_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q <= nx_d; ny_q <= ny_d; d_q <= d_d;
      s2_persp_q <= s1_persp_q;
      s2_last_q  <= s1_last_q;
      s2_dx_q    <= s1_dx_q;
      s2_dy_q    <= s1_dy_q;
    end
  end

  // stage 3: magnitudes, range checks, divider entry
  logic [NW-1:0] nx_abs, ny_abs, d_abs;
  logic [MW-1:0] an_x, an_y, ad;
  mmpp_pkg::div_t div_d, div_q;
  logic           div_valid_q;

  always_comb begin
    nx_abs = nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
    ny_abs = ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
    d_abs  = d_q[NW-1]  ? NW'(-d_q)  : NW'(d_q);
    an_x = nx_abs[MW-1:0];
    an_y = ny_abs[MW-1:0];
    ad   = d_abs[MW-1:0];

    div_d.den      = ad;
    div_d.lx.r     = MW'(an_x >> LOW);
    div_d.lx.lo    = an_x[LOW-1:0];
    div_d.lx.q     = '0;
    div_d.ly.r     = MW'(an_y >> LOW);
    div_d.ly.lo    = an_y[LOW-1:0];
    div_d.ly.q     = '0;
    div_d.side.persp = s2_persp_q;
    div_d.side.bad   = s2_persp_q && (ad <= mmpp_pkg::BAD_DIV_LIMIT);
    div_d.side.last  = s2_last_q;
    div_d.side.ovf_x = {{LOW{1'b0}}, an_x} >= {ad, {LOW{1'b0}}};
    div_d.side.ovf_y = {{LOW{1'b0}}, an_y} >= {ad, {LOW{1'b0}}};
    div_d.side.neg_x = nx_q[NW-1] ^ d_q[NW-1];
    div_d.side.neg_y = ny_q[NW-1] ^ d_q[NW-1];
    div_d.side.dst_x = s2_dx_q;
    div_d.side.dst_y = s2_dy_q;
    div_d.side.lin_x = mmpp_pkg::sat_out(nx_q);
    div_d.side.lin_y = mmpp_pkg::sat_out(ny_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid_q <= 1'b0;
    end else if (en_i) begin
      div_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_valid_o = div_valid_q;
  assign div_o       = div_q;

endmodule

// ===== rtl/mmpp_div.sv =====
// pipelined restoring divider, one quotient bit per stage for both lanes
// depends on mmpp_pkg
`timescale 1ns / 1ps

module mmpp_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mmpp_pkg::div_t data_i,
  output logic           valid_o,
  output mmpp_pkg::div_t data_o
);

  localparam int MW  = mmpp_pkg::MW;
  localparam int QW  = mmpp_pkg::QW;
  localparam int LOW = mmpp_pkg::LOW;

  // one step: bring down the next bit, subtract when it fits
  function automatic mmpp_pkg::lane_t lane_step(input mmpp_pkg::lane_t l,
                                                input logic [MW-1:0] den);
    mmpp_pkg::lane_t o;
    logic [MW:0] rs;
    logic [MW:0] diff;
    logic        fit;
    rs   = {l.r, l.lo[LOW-1]};
    diff = rs - {1'b0, den};
    fit  = rs >= {1'b0, den};
    o.r  = fit ? diff[MW-1:0] : rs[MW-1:0];
    o.lo = {l.lo[LOW-2:0], 1'b0};
    o.q  = {l.q[QW-2:0], fit};
    return o;
  endfunction

  mmpp_pkg::div_t st_d [QW];
  mmpp_pkg::div_t st_q [QW];
  logic [QW-1:0]  vld_q;

  // next value of each stage
  always_comb begin
    st_d[0]    = data_i;
    st_d[0].lx = lane_step(data_i.lx, data_i.den);
    st_d[0].ly = lane_step(data_i.ly, data_i.den);
    for (int k = 1; k < QW; k++) begin
      st_d[k]    = st_q[k-1];
      st_d[k].lx = lane_step(st_q[k-1].lx, st_q[k-1].den);
      st_d[k].ly = lane_step(st_q[k-1].ly, st_q[k-1].den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign data_o  = st_q[QW-1];

endmodule

// ===== rtl/mmpp_post.sv =====
// back end: rounding, saturation, residual and inlier test
// depends on mmpp_pkg
`timescale 1ns / 1ps

module mmpp_post (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mmpp_pkg::div_t data_i,
  output logic           valid_o,
  output mmpp_pkg::res_t res_o
);

  localparam int OW = mmpp_pkg::OW;
  localparam int QW = mmpp_pkg::QW;
  localparam int NW = mmpp_pkg::NW;

  // round to nearest, saturate, apply sign
  function automatic logic [OW-1:0] finish(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
    logic [QW:0]   m1;
    logic [QW-1:0] m;
    logic          big;
    logic [OW-1:0] v;
    m1  = {1'b0, q} + (QW+1)'(1);
    m   = m1[QW:1];
    big = ovf || (m[QW-1:OW-1] != '0);
    if (big) begin
      v = neg ? mmpp_pkg::OUT_MIN : mmpp_pkg::OUT_MAX;
    end else begin
      v = neg ? OW'(-m[OW-1:0]) : m[OW-1:0];
    end
    return v;
  endfunction

  // stage 1: projection and error against destination
  logic [OW-1:0]        prx_d, pry_d, prx_q, pry_q;
  logic signed [NW-1:0] ex_d, ey_d, ex_q, ey_q;
  logic                 v1_q, bad1_q, last1_q;

  always_comb begin
    if (data_i.side.bad) begin
      prx_d = '0;
      pry_d = '0;
    end else if (!data_i.side.persp) begin
      prx_d = data_i.side.lin_x;
      pry_d = data_i.side.lin_y;
    end else begin
      prx_d = finish(data_i.lx.q, data_i.side.ovf_x, data_i.side.neg_x);
      pry_d = finish(data_i.ly.q, data_i.side.ovf_y, data_i.side.neg_y);
    end
    ex_d = $signed({prx_d[OW-1], prx_d})
         - $signed({{17{data_i.side.dst_x[15]}}, data_i.side.dst_x, 16'h0000});
    ey_d = $signed({pry_d[OW-1], pry_d})
         - $signed({{17{data_i.side.dst_y[15]}}, data_i.side.dst_y, 16'h0000});
  end

  // stage 2: magnitudes and range
  logic [NW-1:0] ax, ay;
  logic [31:0]   ax_q, ay_q;
  logic          far_q, v2_q, bad2_q, last2_q;
  logic [OW-1:0] prx2_q, pry2_q;

  assign ax = ex_q[NW-1] ? NW'(-ex_q) : NW'(ex_q);
  assign ay = ey_q[NW-1] ? NW'(-ey_q) : NW'(ey_q);

  // stage 3: squares
  logic [63:0]   sx_q, sy_q;
  logic          far3_q, v3_q, bad3_q, last3_q;
  logic [OW-1:0] prx3_q, pry3_q;

  // stage 4: sum and result
  logic [64:0]    sum;
  mmpp_pkg::res_t res_d, res_q;
  logic           v4_q;

  always_comb begin
    sum = {1'b0, sx_q} + {1'b0, sy_q};
    res_d.proj_x = prx3_q;
    res_d.proj_y = pry3_q;
    res_d.bad    = bad3_q;
    res_d.last   = last3_q;
    if (bad3_q) begin
      res_d.resid  = '0;
      res_d.inlier = 1'b0;
    end else if (far3_q || sum[64]) begin
      res_d.resid  = mmpp_pkg::RES_MAX;
      res_d.inlier = 1'b0;
    end else begin
      res_d.resid  = sum[63:16];
      res_d.inlier = (sum[63:32] == '0);
    end
  end

  // valid bits of the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prx_q <= prx_d; pry_q <= pry_d; ex_q <= ex_d; ey_q <= ey_d;
      bad1_q <= data_i.side.bad; last1_q <= data_i.side.last;

      ax_q <= ax[31:0]; ay_q <= ay[31:0];
      far_q <= (ax[NW-1:32] != '0) || (ay[NW-1:32] != '0);
      bad2_q <= bad1_q; last2_q <= last1_q; prx2_q <= prx_q; pry2_q <= pry_q;

      sx_q <= ax_q * ax_q; sy_q <= ay_q * ay_q;
      far3_q <= far_q; bad3_q <= bad2_q; last3_q <= last2_q;
      prx3_q <= prx2_q; pry3_q <= pry2_q;

      res_q <= res_d;
    end
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/motion_model_point_projector.sv =====
// top level of the motion model point projector: registers, pipeline, output skid
// depends on mmpp_pkg, mmpp_front, mmpp_div, mmpp_post
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    opcode, src_x/y, dst_x/y, last_in
// out       output     out_valid_o / out_ready_i  proj_x/y, residual_sq, inlier,
//                                                 bad_divisor, last_out
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// one request per cycle while in_ready_o is high; 3 front stages, 50 divider stages
// (one quotient bit each, the longest part), 4 back stages
// reset clears valid bits and loads the identity model
// a stalled result moves into a one-entry skid register; the pipeline then
// holds until it drains, so nothing is lost or repeated

module motion_model_point_projector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] src_x_i,
  input  logic [15:0] src_y_i,
  input  logic [15:0] dst_x_i,
  input  logic [15:0] dst_y_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] proj_x_o,
  output logic [47:0] proj_y_o,
  output logic [47:0] residual_sq_o,
  output logic        inlier_o,
  output logic        bad_divisor_o,
  output logic        last_out_o
);

  // model registers
  mmpp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0};
    end else if (cfg_we_i) begin
      case (mmpp_pkg::reg_e'(cfg_idx_i))
        mmpp_pkg::REG_OFFSET_X: cfg_q.offset_x <= cfg_data_i;
        mmpp_pkg::REG_OFFSET_Y: cfg_q.offset_y <= cfg_data_i;
        mmpp_pkg::REG_COEF_XX:  cfg_q.coef_xx  <= cfg_data_i;
        mmpp_pkg::REG_COEF_XY:  cfg_q.coef_xy  <= cfg_data_i;
        mmpp_pkg::REG_COEF_YX:  cfg_q.coef_yx  <= cfg_data_i;
        mmpp_pkg::REG_COEF_YY:  cfg_q.coef_yy  <= cfg_data_i;
        mmpp_pkg::REG_PERSP_X:  cfg_q.persp_x  <= cfg_data_i;
        mmpp_pkg::REG_PERSP_Y:  cfg_q.persp_y  <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // pipeline advances while the skid register is empty
  logic           skid_valid_q;
  mmpp_pkg::res_t skid_q;
  logic           en;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  logic           div_in_valid, div_out_valid, post_valid;
  mmpp_pkg::div_t div_in, div_out;
  mmpp_pkg::res_t post_res, out_res;

  mmpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .src_x_i     ($signed(src_x_i)),
    .src_y_i     ($signed(src_y_i)),
    .dst_x_i     (dst_x_i),
    .dst_y_i     (dst_y_i),
    .last_in_i   (last_in_i),
    .cfg_i       (cfg_q),
    .div_valid_o (div_in_valid),
    .div_o       (div_in)
  );

  mmpp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_in_valid),
    .data_i  (div_in),
    .valid_o (div_out_valid),
    .data_o  (div_out)
  );

  mmpp_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_out_valid),
    .data_i  (div_out),
    .valid_o (post_valid),
    .res_o   (post_res)
  );

  // skid register catches a result that is not taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) skid_valid_q <= 1'b0;
    end else if (post_valid && !out_ready_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q && post_valid && !out_ready_i) begin
      skid_q <= post_res;
    end
  end

  // output select
  assign out_res       = skid_valid_q ? skid_q : post_res;
  assign out_valid_o   = skid_valid_q || post_valid;
  assign proj_x_o      = out_res.proj_x;
  assign proj_y_o      = out_res.proj_y;
  assign residual_sq_o = out_res.resid;
  assign inlier_o      = out_res.inlier;
  assign bad_divisor_o = out_res.bad;
  assign last_out_o    = out_res.last;

  // a flagged divisor gives zero results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_divisor_o |-> proj_x_o == '0 && proj_y_o == '0 &&
                                     residual_sq_o == '0 && !inlier_o)
    else $error("bad divisor with nonzero result");

  // an inlier has a residual below one pixel squared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inlier_o |-> residual_sq_o[47:16] == '0)
    else $error("inlier with large residual");

  // the skid register only fills after a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(post_valid && !out_ready_i))
    else $error("skid filled without a stall");

endmodule
